// ===== sv/sslr_pkg.sv =====
// ----------------------------------------------------------------------------
// sslr_pkg: shared types and constants of the supersampled line rasterizer
// state encoding, control/status bundles, register indexes and limits
// ----------------------------------------------------------------------------
package sslr_pkg;

  // limits of the effective register values
  localparam logic [10:0] MAX_WIDTH  = 11'd1024;
  localparam logic [10:0] MAX_HEIGHT = 11'd1024;
  localparam logic [2:0]  MAX_SSAA   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SS_FACTOR    = 2'd2;

  // item actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_X,
    ST_DIV_Y,
    ST_ROW,
    ST_SCALE,
    ST_EMIT
  } sslr_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic div_x;
    logic div_y;
    logic row;
    logic scale;
    logic emit;
  } sslr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } sslr_sts_t;

endpackage

// ===== sv/sslr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sslr_ctrl: controller of the supersampled line rasterizer
// takes items and sequences line setup and the per-sample index pipeline
// ----------------------------------------------------------------------------
module sslr_ctrl import sslr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_stall,
  input  sslr_sts_t sts,
  output sslr_cmd_t cmd
);

  sslr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_START) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SETUP;
          end else if (sts.busy) begin
            state_nxt = ST_DIV_X;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DIV_X: begin
        cmd.div_x = 1'b1;
        state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd.div_y = 1'b1;
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        cmd.row   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_X |=> state_r == ST_DIV_Y)
    else $error("divider sequence broken");

  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_START |=> state_r == ST_SETUP)
    else $error("start item not followed by setup");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register is held");

endmodule

// ===== sv/sslr_dp.sv =====
// ----------------------------------------------------------------------------
// sslr_dp: datapath of the supersampled line rasterizer
// endpoint scaling, bresenham state, sample index sequencer, output register
// ----------------------------------------------------------------------------
module sslr_dp import sslr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  sslr_cmd_t          cmd,
  output sslr_sts_t          sts,
  input  logic [10:0]        frame_width,
  input  logic [10:0]        frame_height,
  input  logic [2:0]         ss_factor,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_sample_index,
  output logic               out_write_enable,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_last
);

  // q12.4 times s, truncated toward zero
  function automatic logic signed [15:0] to_sample(logic signed [15:0] v, logic [2:0] s);
    logic signed [18:0] p;
    logic signed [18:0] b;
    case (s)
      3'd1:    p = {{3{v[15]}}, v};
      3'd2:    p = {{2{v[15]}}, v, 1'b0};
      3'd3:    p = {{3{v[15]}}, v} + {{2{v[15]}}, v, 1'b0};
      default: p = {v[15], v, 2'b00};
    endcase
    b = p + (p[18] ? 19'sd15 : 19'sd0);
    return {b[18], b[18:4]};
  endfunction

  logic [2:0]  s_eff;
  logic [10:0] w_eff;
  logic [10:0] h_eff;

  always_comb begin
    s_eff = (ss_factor == 3'd0) ? 3'd1 :
            (ss_factor > MAX_SSAA) ? MAX_SSAA : ss_factor;
    w_eff = (frame_width == 11'd0) ? 11'd1 :
            (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
    h_eff = (frame_height == 11'd0) ? 11'd1 :
            (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
  end

  // line state
  logic signed [15:0] pos_x_r, pos_y_r, goal_x_r, goal_y_r;
  logic signed [15:0] span_x_r, span_y_neg_r;
  logic               dir_x_r, dir_y_r;
  logic signed [17:0] error_r;
  logic               busy_r;
  logic [23:0]        color_r;

  // index sequencer
  logic [12:0] qx_r, qy_r;
  logic [1:0]  rx_r, ry_r;
  logic [23:0] row_r;
  logic [4:0]  sub_r;
  logic        inside_r;
  logic [23:0] idx_r;

  // output register
  logic        out_valid_r;
  logic [23:0] out_sample_index_r;
  logic        out_write_enable_r;
  logic [23:0] out_color_r;
  logic        out_last_r;

  // setup arithmetic
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;

  always_comb begin
    dx  = {goal_x_r[15], goal_x_r} - {pos_x_r[15], pos_x_r};
    dy  = {goal_y_r[15], goal_y_r} - {pos_y_r[15], pos_y_r};
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
  end

  // shared divide by s, operand is nonnegative when it matters
  logic [12:0] div_v, div_q, div_t;
  logic [1:0]  div_r;
  logic [28:0] div_m;

  always_comb begin
    div_v = cmd.div_x ? pos_x_r[12:0] : pos_y_r[12:0];
    div_m = {16'd0, div_v} * {13'd0, 16'd43691};
    div_t = 13'd0;
    case (s_eff)
      3'd1: begin
        div_q = div_v;
        div_r = 2'd0;
      end
      3'd2: begin
        div_q = {1'b0, div_v[12:1]};
        div_r = {1'b0, div_v[0]};
      end
      3'd3: begin
        div_q = {1'b0, div_m[28:17]};
        div_t = div_v - div_q - {div_q[11:0], 1'b0};
        div_r = div_t[1:0];
      end
      default: begin
        div_q = {2'b00, div_v[12:2]};
        div_r = div_v[1:0];
      end
    endcase
  end

  // row and scale arithmetic
  logic [23:0] row_prod;
  logic [4:0]  sub_prod;
  logic [23:0] scaled;
  logic        inside_nxt;

  always_comb begin
    row_prod   = {11'd0, qy_r} * {13'd0, w_eff};
    sub_prod   = {3'd0, ry_r} * {2'd0, s_eff};
    inside_nxt = !pos_x_r[15] && !pos_y_r[15] &&
                 (qx_r < {2'b00, w_eff}) && (qy_r < {2'b00, h_eff});
    case (s_eff)
      3'd1:    scaled = row_r;
      3'd2:    scaled = {row_r[21:0], 2'b00};
      3'd3:    scaled = {row_r[20:0], 3'b000} + row_r;
      default: scaled = {row_r[19:0], 4'b0000};
    endcase
  end

  // bresenham advance
  logic               fin;
  logic signed [18:0] e2;
  logic               step_x, step_y;
  logic signed [17:0] error_nxt;

  always_comb begin
    fin       = (pos_x_r == goal_x_r) && (pos_y_r == goal_y_r);
    e2        = {error_r, 1'b0};
    step_x    = e2 >= $signed({{3{span_y_neg_r[15]}}, span_y_neg_r});
    step_y    = e2 <= $signed({{3{span_x_r[15]}}, span_x_r});
    error_nxt = error_r
              + (step_x ? {{2{span_y_neg_r[15]}}, span_y_neg_r} : 18'sd0)
              + (step_y ? {{2{span_x_r[15]}}, span_x_r} : 18'sd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r  <= to_sample(in_start_x, s_eff);
      pos_y_r  <= to_sample(in_start_y, s_eff);
      goal_x_r <= to_sample(in_end_x, s_eff);
      goal_y_r <= to_sample(in_end_y, s_eff);
      color_r  <= {in_red, in_green, in_blue};
    end else if (cmd.emit && !fin) begin
      if (step_x) begin
        pos_x_r <= dir_x_r ? pos_x_r + 16'sd1 : pos_x_r - 16'sd1;
      end
      if (step_y) begin
        pos_y_r <= dir_y_r ? pos_y_r + 16'sd1 : pos_y_r - 16'sd1;
      end
    end
    if (cmd.setup) begin
      span_x_r     <= adx[15:0];
      span_y_neg_r <= 16'(-ady[15:0]);
      dir_x_r      <= pos_x_r < goal_x_r;
      dir_y_r      <= pos_y_r < goal_y_r;
      error_r      <= {2'b00, adx[15:0]} - {2'b00, ady[15:0]};
    end else if (cmd.emit && !fin) begin
      error_r <= error_nxt;
    end
    if (cmd.div_x) begin
      qx_r <= div_q;
      rx_r <= div_r;
    end
    if (cmd.div_y) begin
      qy_r <= div_q;
      ry_r <= div_r;
    end
    if (cmd.row) begin
      row_r    <= row_prod + {11'd0, qx_r};
      sub_r    <= sub_prod + {3'd0, rx_r};
      inside_r <= inside_nxt;
    end
    if (cmd.scale) begin
      idx_r <= inside_r ? scaled + {19'd0, sub_r} : 24'd0;
    end
    if (cmd.emit) begin
      out_sample_index_r <= idx_r;
      out_write_enable_r <= inside_r;
      out_color_r        <= color_r;
      out_last_r         <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        busy_r <= 1'b1;
      end else if (cmd.emit && fin) begin
        busy_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.busy         = busy_r;
  assign sts.out_free     = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_sample_index = out_sample_index_r;
  assign out_write_enable = out_write_enable_r;
  assign out_red          = out_color_r[23:16];
  assign out_green        = out_color_r[15:8];
  assign out_blue         = out_color_r[7:0];
  assign out_last         = out_last_r;

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && fin |=> !busy_r)
    else $error("line still active after last sample");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_write_enable_r |-> out_sample_index_r == 24'd0)
    else $error("outside sample carries nonzero index");

  a_step_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_x |-> busy_r)
    else $error("step sequence started without an active line");

endmodule

// ===== sv/supersampled_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// supersampled_line_rasterizer: bresenham line engine on a supersampled grid
// A start item (action 0) loads two Q12.4 endpoints and a color; the
// endpoints are scaled by the sample factor and truncated toward zero, and
// the line is set up in a setup state that gives no result. Each step item
// (action 1) on an active line gives one result: the flat sample index, the
// color, a write enable (sample inside the frame, negative coordinates
// outside) and a last flag on the final endpoint. For a step the sample
// coordinates pass a shared divide-by-factor unit one axis at a time, then
// the row multiply and the factor scaling are each registered, and the emit
// state moves the result into the output register once that register is
// free. A step on an idle block is taken and gives nothing. The input is
// stalled while an item is in work; a finished result waiting on out_stall
// does not hold off the next item, only the emit of the following result.
// ----------------------------------------------------------------------------
module supersampled_line_rasterizer import sslr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_sample_index,
  output logic               out_write_enable,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_last
);

  // raw register values, clamped inside the datapath on every use
  logic [10:0] frame_width_r;
  logic [10:0] frame_height_r;
  logic [2:0]  ss_factor_r;

  sslr_cmd_t cmd;
  sslr_sts_t sts;

  // plain write port, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= MAX_WIDTH;
      frame_height_r <= MAX_HEIGHT;
      ss_factor_r    <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_SS_FACTOR:    ss_factor_r    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: accepts items, steps the datapath through setup or indexing
  sslr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // line state, index arithmetic and the result register
  sslr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .frame_width      (frame_width_r),
    .frame_height     (frame_height_r),
    .ss_factor        (ss_factor_r),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_index (out_sample_index),
    .out_write_enable (out_write_enable),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last         (out_last)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the supersampled line rasterizer
// Short lines with random colors are started and stepped to their last
// sample, and a few are abandoned. Each accepted item goes through a
// line-walk predictor whose plots are compared with the result channel.
// Both channels idle in random bursts, and the frame registers go through
// several settings, the out-of-range ones among them.
// ----------------------------------------------------------------------------
module testbench import sslr_pkg::*; ();

  // register index that maps to no register
  localparam logic [1:0] REG_SPARE = 2'd3;

  // one item on the input channel
  typedef struct packed {
    logic               action;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } item_t;

  // one plotted sample on the result channel
  typedef struct packed {
    logic [23:0] index;
    logic        we;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } plot_t;

  // line-walk predictor and the queue of plots it still owes
  class line_scoreboard;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [2:0]  factor_reg;
    // walk state, in sample coordinates
    int          cur_x, cur_y, end_sx, end_sy;
    int          run_x, rise_neg, err_acc;
    bit          step_right, step_down, line_active;
    logic [23:0] line_rgb;
    plot_t       plots_due[$];
    int          errors;

    function new();
      width_reg   = MAX_WIDTH;
      height_reg  = MAX_HEIGHT;
      factor_reg  = 3'd1;
      cur_x       = 0;
      cur_y       = 0;
      end_sx      = 0;
      end_sy      = 0;
      run_x       = 0;
      rise_neg    = 0;
      err_acc     = 0;
      step_right  = 1'b0;
      step_down   = 1'b0;
      line_active = 1'b0;
      line_rgb    = '0;
      errors      = 0;
    endfunction

    function int clip(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_width();
      return clip(int'(width_reg), int'(MAX_WIDTH));
    endfunction

    function int eff_height();
      return clip(int'(height_reg), int'(MAX_HEIGHT));
    endfunction

    function int eff_factor();
      return clip(int'(factor_reg), int'(MAX_SSAA));
    endfunction

    // q12.4 pixel coordinate to sample coordinate, truncated toward zero
    function int to_grid(logic signed [15:0] q, int s);
      int p;
      p = q * s;
      return p / 16;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        REG_SS_FACTOR:    factor_reg = data[2:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return plots_due.size();
    endfunction

    // advance the walk by one accepted item
    function void note_item(item_t it);
      int    s, w, h, px, py, idx, e2;
      bit    fin;
      plot_t p;
      s = eff_factor();
      w = eff_width();
      h = eff_height();
      if (it.action == ACT_START) begin
        cur_x       = to_grid(it.start_x, s);
        cur_y       = to_grid(it.start_y, s);
        end_sx      = to_grid(it.end_x, s);
        end_sy      = to_grid(it.end_y, s);
        run_x       = (end_sx > cur_x) ? end_sx - cur_x : cur_x - end_sx;
        rise_neg    = (end_sy > cur_y) ? cur_y - end_sy : end_sy - cur_y;
        step_right  = cur_x < end_sx;
        step_down   = cur_y < end_sy;
        err_acc     = run_x + rise_neg;
        line_rgb    = {it.red, it.green, it.blue};
        line_active = 1'b1;
        return;
      end
      // a step with no line in progress is ignored
      if (!line_active) return;
      p     = '0;
      idx   = 0;
      fin   = (cur_x == end_sx) && (cur_y == end_sy);
      // negative samples are outside even though x / s would give pixel 0
      if (cur_x >= 0 && cur_y >= 0) begin
        px = cur_x / s;
        py = cur_y / s;
        if (px < w && py < h) begin
          p.we = 1'b1;
          idx  = (px + py * w) * s * s + (cur_y % s) * s + (cur_x % s);
        end
      end
      p.index = idx[23:0];
      p.red   = line_rgb[23:16];
      p.green = line_rgb[15:8];
      p.blue  = line_rgb[7:0];
      p.last  = fin;
      plots_due.insert(plots_due.size(), p);
      if (fin) begin
        line_active = 1'b0;
      end else begin
        e2 = 2 * err_acc;
        if (e2 >= rise_neg) begin
          err_acc += rise_neg;
          cur_x   += step_right ? 1 : -1;
        end
        if (e2 <= run_x) begin
          err_acc += run_x;
          cur_y   += step_down ? 1 : -1;
        end
      end
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(plot_t got);
      plot_t want;
      if (plots_due.size() == 0) begin
        $display("%0t: result with nothing expected, actual index %0h", $time, got.index);
        errors++;
        return;
      end
      want = plots_due.pop_front();
      if (got.index !== want.index) report("sample_index", want.index, got.index);
      if (got.we !== want.we)       report("write_enable", want.we, got.we);
      if (got.red !== want.red)     report("red", want.red, got.red);
      if (got.green !== want.green) report("green", want.green, got.green);
      if (got.blue !== want.blue)   report("blue", want.blue, got.blue);
      if (got.last !== want.last)   report("last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [10:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = 1'b0;
  logic signed [15:0] in_start_x = '0;
  logic signed [15:0] in_start_y = '0;
  logic signed [15:0] in_end_x = '0;
  logic signed [15:0] in_end_y = '0;
  logic [7:0]         in_red = '0;
  logic [7:0]         in_green = '0;
  logic [7:0]         in_blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [23:0]        out_sample_index;
  logic               out_write_enable;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               out_last;

  line_scoreboard sb = new();
  int             items_sent = 0;
  // no idling on either side once this is set
  logic           calm_tail = 1'b0;
  int             stall_left = 0;

  supersampled_line_rasterizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_index (out_sample_index),
    .out_write_enable (out_write_enable),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver back-pressure: random bursts of stalled cycles between open runs
  always @(posedge clk) begin
    if (!rst_n || calm_tail) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor, sampled with the pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_sample_index, out_write_enable, out_red, out_green, out_blue,
                       out_last});
  end

  // start item with a random color
  function automatic item_t make_start(int sx, int sy, int ex, int ey);
    item_t it;
    it.action  = ACT_START;
    it.start_x = 16'(sx);
    it.start_y = 16'(sy);
    it.end_x   = 16'(ex);
    it.end_y   = 16'(ey);
    it.red     = 8'($urandom());
    it.green   = 8'($urandom());
    it.blue    = 8'($urandom());
    return it;
  endfunction

  // step item; the other fields carry noise the block must ignore
  function automatic item_t step_item();
    item_t it;
    it        = make_start($urandom(), $urandom(), $urandom(), $urandom());
    it.action = ACT_STEP;
    return it;
  endfunction

  // present one item, hold it while stalled, note it when taken
  task automatic send(item_t it);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= it.action;
    in_start_x <= it.start_x;
    in_start_y <= it.start_y;
    in_end_x   <= it.end_x;
    in_end_y   <= it.end_y;
    in_red     <= it.red;
    in_green   <= it.green;
    in_blue    <= it.blue;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    items_sent++;
  endtask

  // step until the line has given its last sample
  task automatic finish_line();
    while (sb.line_active) send(step_item());
  endtask

  task automatic run_line(item_t it);
    send(it);
    finish_line();
  endtask

  // let the block run dry so registers can be written safely
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a start or an ignored step may still be in work without a result
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // factor written with junk in the bits above the register
  task automatic configure(logic [10:0] w, logic [10:0] h, logic [2:0] f);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_SS_FACTOR, {8'($urandom()), f});
    cfg_we <= 1'b0;
  endtask

  // short line near the frame, mostly inside, now and then a longer one
  task automatic random_line(bit complete);
    int reach, x0, y0, x1, y1;
    reach = ($urandom_range(0, 9) == 0) ? 160 : 48;
    x0    = int'($urandom_range(0, (sb.eff_width() + 4) * 16)) - 32;
    y0    = int'($urandom_range(0, (sb.eff_height() + 4) * 16)) - 32;
    x1    = x0 + int'($urandom_range(0, 2 * reach)) - reach;
    y1    = y0 + int'($urandom_range(0, 2 * reach)) - reach;
    send(make_start(x0, y0, x1, y1));
    if (complete) begin
      finish_line();
      // trailing step on an idle block
      if ($urandom_range(0, 4) == 0) send(step_item());
    end else begin
      repeat ($urandom_range(0, 3)) send(step_item());
    end
  endtask

  task automatic random_part(int item_goal);
    int pick;
    while (items_sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        random_line(1'b1);
      end else if (pick < 85) begin
        random_line(1'b0);
      end else if (pick < 93) begin
        // full-range endpoints, abandoned after a few samples
        send(make_start($urandom(), $urandom(), $urandom(), $urandom()));
        repeat ($urandom_range(0, 2)) send(step_item());
      end else begin
        send(step_item());
      end
    end
  endtask

  initial begin
    item_t it;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, 1024 x 1024 frame, one sample per pixel
    // step with no line loaded
    send(step_item());
    // crossing x = 0: samples -2 and -1 are outside, not folded into pixel 0
    it = make_start(-32, 0, 16, 0);
    it.red   = 8'hff;
    it.green = 8'h00;
    it.blue  = 8'hff;
    run_line(it);
    send(step_item());
    // single-sample line at the top of the coordinate range
    it = make_start(32767, 32767, 32767, 32767);
    it.red   = 8'h00;
    it.green = 8'h00;
    it.blue  = 8'h00;
    run_line(it);
    // bottom of the range, abandoned by the next start
    it = make_start(-32768, -32768, -32720, -32752);
    it.red   = 8'hff;
    it.green = 8'hff;
    it.blue  = 8'hff;
    send(it);
    send(step_item());
    send(step_item());
    // diagonal walking up-left from the last pixel
    run_line(make_start(16383, 16383, 16320, 16320));
    // vertical, walking up
    run_line(make_start(1600, 80, 1600, 32));
    settle();

    // 2x2 samples on a common frame
    configure(11'd640, 11'd480, 3'd2);
    random_part(100);
    settle();

    // zero size and factor 7 clamp to a 1 x 1 frame with 4x4 samples;
    // a write to the unmapped index must change nothing
    configure(11'd0, 11'd0, 3'd7);
    write_reg(REG_SPARE, 11'($urandom()));
    cfg_we <= 1'b0;
    random_part(170);
    settle();

    // oversize frame and factor 0 clamp to 1024 x 1024 at one sample
    configure(11'd2047, 11'd2047, 3'd0);
    random_part(240);
    settle();

    // largest grid; the corner line reaches the top sample index
    configure(11'd1024, 11'd1024, 3'd4);
    run_line(make_start(16383, 16383, 16400, 16383));
    random_part(310);
    settle();

    configure(11'd1, 11'd1024, 3'd3);
    random_part(380);
    settle();

    // closing phase runs with both sides always ready
    configure(11'd800, 11'd600, 3'd3);
    calm_tail <= 1'b1;
    random_part(450);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** supersampled_line_rasterizer: PASSED **");
    end else begin
      $display("** supersampled_line_rasterizer: FAILED **");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("** supersampled_line_rasterizer: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sslr_pkg.sv
sv/sslr_ctrl.sv
sv/sslr_dp.sv
sv/supersampled_line_rasterizer.sv
sim/testbench.sv
